FILE: rtl/hungarian_assignment_solver_macros.svh
// Assertion helpers shared by the solver RTL.
`ifndef HUNGARIAN_ASSIGNMENT_SOLVER_MACROS_SVH
`define HUNGARIAN_ASSIGNMENT_SOLVER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define HAS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked at the following clock edge.
`define HAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/has_pkg.sv
package has_pkg;

  localparam int unsigned COST_W = 16;
  localparam int unsigned IDX_W = 3;

  typedef struct packed {
    logic [COST_W-1:0] assigned_cost;
    logic [IDX_W-1:0]  column_index;
    logic [IDX_W-1:0]  row_index;
  } result_t;

endpackage

FILE: rtl/hungarian_assignment_solver.sv
// Hungarian assignment solver.
// Input stream (s_axis_*): one unsigned cost per transfer, row-major; SIZE*SIZE
// transfers make one matrix, and only the low COST_BITS bits of each cost are used.
// While a matrix loads, the block takes one transfer per cycle. After the last
// element it drops s_axis_tready and solves: row and column reduction, then
// repeated rounds of zero-only matching (depth-first search with a stack),
// minimum line cover and an adjustment of the working copy. All of this runs on
// one shared compare/subtract unit that visits a single matrix element at a time.
// Each visit presents the address, then takes the registered read data.
// Output stream (m_axis_*): SIZE result transfers, one per row in ascending
// order, with the assigned column and the original cost; tlast marks the final
// row. Each result steps through a column lookup, a cost read and the output
// state. A stalled receiver simply holds the current result. The next matrix is
// accepted only after the last result transfer.
// Reset (rst, synchronous, active high) returns the block to loading an
// empty matrix; the cost stores themselves are not cleared.
module hungarian_assignment_solver #(
  parameter int unsigned SIZE = 8,
  parameter int unsigned COST_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] cost
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] row_index, [5:3] column_index,
                                      // [21:6] assigned_cost, [23:22] zero
  output logic        m_axis_tlast    // last_of_run
);

  localparam int unsigned CELLS = SIZE * SIZE;
  localparam int unsigned IW = $clog2(SIZE);
  localparam int unsigned AW = $clog2(CELLS);
  localparam int unsigned WW = COST_BITS + 2;
  localparam int unsigned CNTW = $clog2(CELLS + 2);
  localparam logic [WW-1:0] WORK_MAX = '1;

  typedef enum logic [4:0] {
    S_LOAD, S_RMIN, S_RSUB, S_CMIN, S_CSUB,
    S_MINIT, S_MROW, S_MSCAN, S_MFOUND, S_MUNWIND,
    S_CVINIT, S_CVROWS, S_CVCOLS, S_CVCHK,
    S_AMIN, S_ASUB, S_OUTCOL, S_OUTRD, S_OUT
  } state_t;

  state_t state;

  logic [COST_BITS-1:0] orig_mem [CELLS];
  logic [WW-1:0]        work_mem [CELLS];

  logic [AW-1:0] load_count;
  logic [IW-1:0] ri, ci;
  logic [WW-1:0] acc;
  logic          found;
  logic          phase;
  logic [SIZE-1:0] owner_valid;
  logic [IW-1:0]   owner [SIZE];
  logic [IW-1:0]   stk_row [SIZE+1];
  logic [IW-1:0]   stk_via [SIZE+1];
  logic [IW:0]     stk_next [SIZE+1];
  logic [IW:0]     depth;
  logic [IW:0]     match_count;
  logic [SIZE-1:0] seen, rows, cols, rows_old, cols_old;
  logic [SIZE-1:0] matched_rows, grow_rows;
  logic [CNTW-1:0] round;
  logic [IW-1:0]   start_row;
  logic [IW:0]     unwind;
  logic [IW-1:0]   out_col;
  logic [IW-1:0]   out_col_next;
  logic [COST_BITS-1:0] orig_rd;
  logic [COST_BITS-1:0] in_cost;

  assign in_cost = COST_BITS'(s_axis_tdata);

  logic [IW-1:0] cur_row;
  logic [IW:0]   cur_next;
  assign cur_row  = stk_row[depth];
  assign cur_next = stk_next[depth];

  logic [AW-1:0] srch_addr;
  assign srch_addr = AW'(cur_row) * AW'(SIZE) + AW'(cur_next[IW-1:0]);

  // Shared element access: one read address per cycle, data registered in wv.
  logic [AW-1:0] addr;
  logic [AW-1:0] out_addr;
  logic [WW-1:0] wv;
  logic          cur_ri_row;
  assign addr = (state == S_MSCAN) ? srch_addr : AW'(ri) * AW'(SIZE) + AW'(ci);
  assign out_addr = AW'(ri) * AW'(SIZE) + AW'(out_col);

  has_pkg::result_t res;

  assign s_axis_tready = (state == S_LOAD);

  logic [SIZE-1:0] full_mask;
  assign full_mask = '1;

  assign cur_ri_row = rows[ri];

  // Rows held by the matching, rows reached through covered columns, and the
  // lowest column owned by the row being reported.
  always_comb begin
    matched_rows = '0;
    grow_rows = '0;
    out_col_next = '0;
    for (int j = 0; j < SIZE; j++) begin
      if (owner_valid[j]) matched_rows[owner[j]] = 1'b1;
      if (owner_valid[j] && cols[j]) grow_rows[owner[j]] = 1'b1;
    end
    for (int j = SIZE - 1; j >= 0; j--)
      if (owner_valid[j] && owner[j] == ri) out_col_next = IW'(j);
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD && s_axis_tvalid) begin
      orig_mem[load_count] <= in_cost;
      work_mem[load_count] <= WW'(in_cost);
    end else if (phase && (state == S_RSUB || state == S_CSUB)) begin
      work_mem[addr] <= wv - acc;
    end else if (phase && state == S_ASUB) begin
      if (!rows[ri] && !cols[ci]) begin
        work_mem[addr] <= wv - acc;
      end else if (rows[ri] && cols[ci]) begin
        work_mem[addr] <= (wv > WORK_MAX - acc) ? WORK_MAX : wv + acc;
      end
    end
    wv <= work_mem[addr];
    if (state == S_OUTRD) begin
      orig_rd <= orig_mem[out_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      load_count <= '0;
      m_axis_tvalid <= 1'b0;
      owner_valid <= '0;
      phase <= 1'b0;
      ri <= '0;
      ci <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (s_axis_tvalid) begin
            if (load_count == AW'(CELLS - 1)) begin
              load_count <= '0;
              ri <= '0;
              ci <= '0;
              round <= '0;
              phase <= 1'b0;
              state <= S_RMIN;
            end else begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        S_RMIN: begin
          if (!phase) phase <= 1'b1;
          else begin
            phase <= 1'b0;
            if (ci == '0 || wv < acc) acc <= wv;
            if (ci == IW'(SIZE - 1)) begin
              ci <= '0;
              state <= S_RSUB;
            end else ci <= ci + 1'b1;
          end
        end
        S_RSUB: begin
          if (!phase) phase <= 1'b1;
          else begin
            phase <= 1'b0;
            if (ci == IW'(SIZE - 1)) begin
              ci <= '0;
              if (ri == IW'(SIZE - 1)) begin
                ri <= '0;
                state <= S_CMIN;
              end else begin
                ri <= ri + 1'b1;
                state <= S_RMIN;
              end
            end else ci <= ci + 1'b1;
          end
        end
        S_CMIN: begin
          if (!phase) phase <= 1'b1;
          else begin
            phase <= 1'b0;
            if (ri == '0 || wv < acc) acc <= wv;
            if (ri == IW'(SIZE - 1)) begin
              ri <= '0;
              state <= S_CSUB;
            end else ri <= ri + 1'b1;
          end
        end
        S_CSUB: begin
          if (!phase) phase <= 1'b1;
          else begin
            phase <= 1'b0;
            if (ri == IW'(SIZE - 1)) begin
              ri <= '0;
              if (ci == IW'(SIZE - 1)) begin
                ci <= '0;
                state <= S_MINIT;
              end else begin
                ci <= ci + 1'b1;
                state <= S_CMIN;
              end
            end else ri <= ri + 1'b1;
          end
        end
        S_MINIT: begin
          owner_valid <= '0;
          match_count <= '0;
          start_row <= '0;
          state <= S_MROW;
        end
        S_MROW: begin
          seen <= '0;
          depth <= '0;
          stk_row[0] <= start_row;
          stk_next[0] <= '0;
          state <= S_MSCAN;
        end
        S_MSCAN: begin
          // One column of the current search row per element visit.
          if (!phase) phase <= 1'b1;
          else begin
            phase <= 1'b0;
            if (cur_next == (IW+1)'(SIZE)) begin
              if (depth == '0) begin
                // The row is left unmatched.
                if (start_row == IW'(SIZE - 1)) state <= S_CVINIT;
                else begin
                  start_row <= start_row + 1'b1;
                  state <= S_MROW;
                end
              end else depth <= depth - 1'b1;
            end else if (wv == '0 && !seen[cur_next[IW-1:0]]) begin
              seen[cur_next[IW-1:0]] <= 1'b1;
              stk_via[depth] <= cur_next[IW-1:0];
              stk_next[depth] <= cur_next + 1'b1;
              state <= S_MFOUND;
            end else begin
              stk_next[depth] <= cur_next + 1'b1;
            end
          end
        end
        S_MFOUND: begin
          if (!owner_valid[stk_via[depth]]) begin
            unwind <= depth;
            state <= S_MUNWIND;
          end else begin
            depth <= depth + 1'b1;
            stk_row[depth + 1'b1] <= owner[stk_via[depth]];
            stk_next[depth + 1'b1] <= '0;
            state <= S_MSCAN;
          end
        end
        S_MUNWIND: begin
          owner[stk_via[unwind]] <= stk_row[unwind];
          owner_valid[stk_via[unwind]] <= 1'b1;
          if (unwind == '0) begin
            match_count <= match_count + 1'b1;
            if (start_row == IW'(SIZE - 1)) state <= S_CVINIT;
            else begin
              start_row <= start_row + 1'b1;
              state <= S_MROW;
            end
          end else unwind <= unwind - 1'b1;
        end
        S_CVINIT: begin
          if (match_count == (IW+1)'(SIZE)) begin
            ri <= '0;
            state <= S_OUTCOL;
          end else begin
            rows <= full_mask & ~matched_rows;
            cols <= '0;
            ri <= '0;
            ci <= '0;
            state <= S_CVROWS;
          end
        end
        S_CVROWS: begin
          if (!phase) phase <= 1'b1;
          else begin
            phase <= 1'b0;
            if (ci == '0 && ri == '0) begin
              rows_old <= rows;
              cols_old <= cols;
            end
            if (cur_ri_row && wv == '0) cols[ci] <= 1'b1;
            if (ci == IW'(SIZE - 1)) begin
              ci <= '0;
              if (ri == IW'(SIZE - 1)) begin
                ri <= '0;
                state <= S_CVCOLS;
              end else ri <= ri + 1'b1;
            end else ci <= ci + 1'b1;
          end
        end
        S_CVCOLS: begin
          rows <= rows | grow_rows;
          state <= S_CVCHK;
        end
        S_CVCHK: begin
          if (rows != rows_old || cols != cols_old) begin
            state <= S_CVROWS;
          end else begin
            // rows now holds uncovered rows until S_AMIN inverts it.
            found <= 1'b0;
            acc <= WORK_MAX;
            state <= S_AMIN;
          end
        end
        S_AMIN: begin
          if (!phase) phase <= 1'b1;
          else begin
            phase <= 1'b0;
            if (rows[ri] && !cols[ci] && (!found || wv < acc)) begin
              acc <= wv;
              found <= 1'b1;
            end
            if (ci == IW'(SIZE - 1)) begin
              ci <= '0;
              if (ri == IW'(SIZE - 1)) begin
                ri <= '0;
                rows <= ~rows;
                state <= S_ASUB;
              end else ri <= ri + 1'b1;
            end else ci <= ci + 1'b1;
          end
        end
        S_ASUB: begin
          if (!found) begin
            ri <= '0;
            state <= S_OUTCOL;
          end else if (!phase) phase <= 1'b1;
          else begin
            phase <= 1'b0;
            if (ci == IW'(SIZE - 1)) begin
              ci <= '0;
              if (ri == IW'(SIZE - 1)) begin
                ri <= '0;
                // The round limit ends the solve with the last matching.
                if (round == CNTW'(CELLS)) state <= S_OUTCOL;
                else begin
                  round <= round + 1'b1;
                  state <= S_MINIT;
                end
              end else ri <= ri + 1'b1;
            end else ci <= ci + 1'b1;
          end
        end
        S_OUTCOL: begin
          out_col <= out_col_next;
          state <= S_OUTRD;
        end
        S_OUTRD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            res.row_index <= 3'(ri);
            res.column_index <= 3'(out_col);
            res.assigned_cost <= 16'(orig_rd);
            m_axis_tlast <= (ri == IW'(SIZE - 1));
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (ri == IW'(SIZE - 1)) begin
              ri <= '0;
              state <= S_LOAD;
            end else begin
              ri <= ri + 1'b1;
              state <= S_OUTCOL;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign m_axis_tdata = {2'b00, res};

`include "hungarian_assignment_solver_macros.svh"

  `HAS_ASSERT_IMPLY(a_no_ready_busy, clk, rst, state != S_LOAD, !s_axis_tready, "ready while busy")
  `HAS_ASSERT_IMPLY(a_out_only_out, clk, rst, m_axis_tvalid, state == S_OUT, "valid outside output")
  `HAS_ASSERT_NEXT(a_hold_out, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")

endmodule

FILE: dv/hungarian_assignment_solver_test.sv
module hungarian_assignment_solver_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N = 8;
  localparam int unsigned CELLS = N * N;
  localparam int unsigned WORK_BITS = has_pkg::COST_W + 2;
  localparam logic [WORK_BITS-1:0] WORK_MAX = '1;
  localparam logic [3:0] UNASSIGNED = 4'hF;
  // A cycle limit without any transfer; even a solve that runs to its round limit
  // stays far below this, and so does the longest output stall.
  localparam int unsigned IDLE_LIMIT = 2000000;

  typedef struct {
    logic [has_pkg::IDX_W-1:0]  row_index;
    logic [has_pkg::IDX_W-1:0]  column_index;
    logic [has_pkg::COST_W-1:0] assigned_cost;
    logic                       last_of_run;
  } assignment_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  hungarian_assignment_solver #(.SIZE(N), .COST_BITS(has_pkg::COST_W)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  always #6 clk = ~clk;

  // Predictor state: the matrix as it loads, and its working copy during a solve.
  logic [has_pkg::COST_W-1:0] orig_cost [CELLS];
  logic [WORK_BITS-1:0]       work_cost [CELLS];
  logic [3:0]                 col_owner [N];
  logic [N-1:0]               seen_cols;
  int unsigned                cells_loaded = 0;

  assignment_t pending_assignments[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          stall_enabled = 1'b1;

  // Short gaps most of the time, an occasional long one.
  function automatic int unsigned gap_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Depth-first search for an augmenting path along zero entries, with an
  // explicit stack of rows, the column each level resumes at and the column used.
  function automatic bit augment_from(int unsigned start);
    int unsigned stack_row [N+1];
    int unsigned resume_col [N+1];
    int unsigned used_col [N+1];
    int unsigned depth;
    int unsigned row;
    int unsigned j;
    int unsigned owner;
    depth = 0;
    stack_row[0] = start;
    resume_col[0] = 0;
    forever begin
      row = stack_row[depth];
      j = resume_col[depth];
      while (j < N && !(work_cost[row*N+j] == 0 && !seen_cols[j])) j++;
      if (j < N) begin
        seen_cols[j] = 1'b1;
        resume_col[depth] = j + 1;
        used_col[depth] = j;
        owner = col_owner[j];
        if (col_owner[j] == UNASSIGNED || owner >= N) begin
          for (int k = depth; k >= 0; k--) col_owner[used_col[k]] = stack_row[k][3:0];
          return 1'b1;
        end
        if (depth + 1 > N) return 1'b0;
        depth++;
        stack_row[depth] = owner;
        resume_col[depth] = 0;
      end else begin
        if (depth == 0) return 1'b0;
        depth--;
      end
    end
  endfunction

  function automatic int unsigned match_zeros();
    int unsigned matched;
    matched = 0;
    for (int r = 0; r < N; r++) col_owner[r] = UNASSIGNED;
    for (int r = 0; r < N; r++) begin
      seen_cols = '0;
      if (augment_from(r)) matched++;
    end
    return matched;
  endfunction

  // Cover lines from the matching, then shift the smallest uncovered value.
  // Returns 0 when no uncovered entry exists.
  function automatic bit cover_and_shift();
    logic [N-1:0]         matched_rows;
    logic [N-1:0]         rows;
    logic [N-1:0]         cols;
    logic [N-1:0]         old_rows;
    logic [N-1:0]         old_cols;
    logic [N-1:0]         row_cov;
    logic [WORK_BITS-1:0] least;
    bit                   found;
    matched_rows = '0;
    cols = '0;
    for (int j = 0; j < N; j++)
      if (col_owner[j] < N) matched_rows[col_owner[j]] = 1'b1;
    rows = ~matched_rows;
    do begin
      old_rows = rows;
      old_cols = cols;
      for (int i = 0; i < N; i++)
        if (rows[i])
          for (int j = 0; j < N; j++)
            if (work_cost[i*N+j] == 0) cols[j] = 1'b1;
      for (int j = 0; j < N; j++)
        if (cols[j] && col_owner[j] < N) rows[col_owner[j]] = 1'b1;
    end while (rows != old_rows || cols != old_cols);
    row_cov = ~rows;
    least = WORK_MAX;
    found = 1'b0;
    for (int i = 0; i < N; i++)
      for (int j = 0; j < N; j++)
        if (!row_cov[i] && !cols[j] && (!found || work_cost[i*N+j] < least)) begin
          least = work_cost[i*N+j];
          found = 1'b1;
        end
    if (!found) return 1'b0;
    for (int i = 0; i < N; i++)
      for (int j = 0; j < N; j++)
        if (!row_cov[i] && !cols[j])
          work_cost[i*N+j] -= least;
        else if (row_cov[i] && cols[j])
          work_cost[i*N+j] = (work_cost[i*N+j] > WORK_MAX - least) ?
                             WORK_MAX : work_cost[i*N+j] + least;
    return 1'b1;
  endfunction

  // Solve the loaded matrix and queue one assignment per row.
  task automatic solve_assignment();
    logic [WORK_BITS-1:0] least;
    assignment_t          a;
    int unsigned          col;
    for (int i = 0; i < N; i++) begin
      least = work_cost[i*N];
      for (int j = 1; j < N; j++) if (work_cost[i*N+j] < least) least = work_cost[i*N+j];
      for (int j = 0; j < N; j++) work_cost[i*N+j] -= least;
    end
    for (int j = 0; j < N; j++) begin
      least = work_cost[j];
      for (int i = 1; i < N; i++) if (work_cost[i*N+j] < least) least = work_cost[i*N+j];
      for (int i = 0; i < N; i++) work_cost[i*N+j] -= least;
    end
    for (int round = 0; round <= CELLS; round++) begin
      if (match_zeros() == N) break;
      if (!cover_and_shift()) break;
    end
    for (int r = 0; r < N; r++) begin
      col = 0;
      for (int j = 0; j < N; j++)
        if (col_owner[j] == r) begin
          col = j;
          break;
        end
      a.row_index = r[has_pkg::IDX_W-1:0];
      a.column_index = col[has_pkg::IDX_W-1:0];
      a.assigned_cost = orig_cost[r*N+col];
      a.last_of_run = (r == N - 1);
      pending_assignments.push_back(a);
    end
  endtask

  // Offer one cost, hold it until the transfer, then update the predictor.
  // A gap before the offer drops tvalid; without one, costs follow back to back.
  task automatic send_cost(input logic [15:0] cost);
    int unsigned gap;
    gap = gap_length();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= cost;
    do @(posedge clk); while (!s_axis_tready);
    orig_cost[cells_loaded] = cost;
    work_cost[cells_loaded] = {2'b00, cost};
    cells_loaded++;
    if (cells_loaded == CELLS) begin
      cells_loaded = 0;
      solve_assignment();
    end
    @(negedge clk);
  endtask

  task automatic send_matrix(input logic [15:0] m [CELLS]);
    for (int k = 0; k < CELLS; k++) send_cost(m[k]);
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver back-pressure, changed at the falling edge.
  initial begin
    int unsigned hold;
    forever begin
      @(negedge clk);
      if (!stall_enabled) begin
        m_axis_tready <= 1'b1;
      end else begin
        hold = gap_length();
        m_axis_tready <= (hold == 0);
        repeat (hold) @(negedge clk);
        if (hold != 0) m_axis_tready <= 1'b1;
      end
    end
  end

  // Result checker: each transfer against the oldest pending assignment.
  always @(posedge clk) begin
    assignment_t exp_a;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_assignments.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: tdata=%h", m_axis_tdata);
      end else begin
        exp_a = pending_assignments.pop_front();
        if (m_axis_tdata[2:0] !== exp_a.row_index ||
            m_axis_tdata[5:3] !== exp_a.column_index ||
            m_axis_tdata[21:6] !== exp_a.assigned_cost ||
            m_axis_tdata[23:22] !== 2'b00 ||
            m_axis_tlast !== exp_a.last_of_run) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected row %0d col %0d cost %0d last %0b, ",
                      "got row %0d col %0d cost %0d last %0b pad %b"},
                     exp_a.row_index, exp_a.column_index, exp_a.assigned_cost,
                     exp_a.last_of_run, m_axis_tdata[2:0], m_axis_tdata[5:3],
                     m_axis_tdata[21:6], m_axis_tlast, m_axis_tdata[23:22]);
        end
      end
    end
  end

  // Watchdog: counts cycles in which no transfer happens on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Maximum costs everywhere but one diagonal of zero costs.
  task automatic test_extremes();
    logic [15:0] m [CELLS];
    for (int k = 0; k < CELLS; k++) m[k] = (k % (N + 1) == 0) ? 16'h0000 : 16'hFFFF;
    send_matrix(m);
  endtask

  // One column much cheaper than all others, so every row wants it and
  // several cover-and-shift rounds are needed.
  task automatic test_structured();
    logic [15:0] m [CELLS];
    for (int i = 0; i < N; i++)
      for (int j = 0; j < N; j++) m[i*N+j] = (j == 0) ? 16'(i) : 16'(60000 + i * j);
    send_matrix(m);
  endtask

  // Random matrices: mostly small values with many ties, some full range.
  task automatic test_random(input int unsigned count);
    logic [15:0] m [CELLS];
    int unsigned style;
    for (int t = 0; t < count; t++) begin
      style = $urandom_range(0, 2);
      for (int k = 0; k < CELLS; k++)
        case (style)
          0: m[k] = 16'($urandom_range(0, 7));
          1: m[k] = 16'($urandom_range(0, 300));
          default: m[k] = 16'($urandom);
        endcase
      send_matrix(m);
    end
  endtask

  task automatic wait_for_results();
    while (pending_assignments.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_structured();
    test_random(1);
    // A burst with no receiver back-pressure.
    stall_enabled = 1'b0;
    test_random(1);
    wait_for_results();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
